FILE: rtl/orq_pkg.sv
package orq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 2;
    localparam int DESC_W    = 16;
    localparam int STAMP_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int ENTRY_W   = DESC_W + STAMP_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_POP_HEAD = 2'd1,
        OP_POP_TAIL = 2'd2,
        OP_CANCEL   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } state_t;

endpackage

FILE: rtl/orq_ram.sv
module orq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ordered_request_queue_with_cancel.sv
// Ordered request queue of up to DEPTH entries (descriptor, arrival stamp) held in
// one circular RAM with a registered read port. An item is taken when start is high
// and busy is low; its single result appears on done in the cycle after the item
// finishes, and the receiver cannot stall it. Append, and every refused operation
// (full, empty, cancel on an empty queue), finish in the accept cycle: result in the
// next cycle, next item may follow at once. Remove head or tail goes through S_POP
// (one RAM read). Cancel walks the queue from the head through one shared
// descriptor comparator, one entry per cycle, until it reaches the match or the last
// held entry; after a match, S_SHIFT uses the single RAM port pair to move each
// later entry down one place. No clearing pass is needed after reset.
module ordered_request_queue_with_cancel #(
    parameter int DEPTH = orq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [orq_pkg::OP_W-1:0]      op,
    input  logic [orq_pkg::DESC_W-1:0]    desc_in,
    input  logic [orq_pkg::STAMP_W-1:0]   stamp_in,
    output logic                          done,
    output logic [orq_pkg::STATUS_W-1:0]  status,
    output logic [orq_pkg::DESC_W-1:0]    desc_out,
    output logic [orq_pkg::STAMP_W-1:0]   stamp_out,
    output logic [orq_pkg::COUNT_W-1:0]   count_out
);

    import orq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [DESC_W-1:0]    key_reg, key_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [DESC_W-1:0]    desc_out_reg, desc_out_next;
    logic [STAMP_W-1:0]   stamp_out_reg, stamp_out_next;
    logic [COUNT_W-1:0]   count_out_reg, count_out_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic [DESC_W-1:0]    rd_desc;
    logic [STAMP_W-1:0]   rd_stamp;

    logic                 accept;
    logic                 q_empty;
    logic                 q_full;
    logic                 match;
    logic                 last_scan;
    logic                 last_shift;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] prv(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    orq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign q_empty    = (count_reg == '0);
    assign q_full     = (count_reg == CW'(DEPTH));
    assign rd_desc    = rd_data[ENTRY_W-1 -: DESC_W];
    assign rd_stamp   = rd_data[STAMP_W-1:0];
    assign match      = (rd_desc == key_reg);
    assign last_scan  = (CW'(idx_reg) == count_reg - CW'(1));
    assign last_shift = (CW'(idx_reg) + CW'(1) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op_t'(op) == OP_POP_HEAD || op_t'(op) == OP_POP_TAIL) && !q_empty)
                    begin
                        state_next = S_POP;
                    end
                    else if (op_t'(op) == OP_CANCEL && !q_empty)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                priority if (match && !last_scan)
                begin
                    state_next = S_SHIFT;
                end
                else if (match || last_scan)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SHIFT:
            begin
                if (last_shift)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        src_next       = src_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        desc_out_next  = desc_out_reg;
        stamp_out_next = stamp_out_reg;
        count_out_next = count_out_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = {desc_in, stamp_in};
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    desc_out_next  = '0;
                    stamp_out_next = '0;
                    count_out_next = COUNT_W'(count_reg);
                    unique case (op_t'(op))
                        OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (q_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                tail_next      = nxt(tail_reg);
                                count_next     = count_reg + CW'(1);
                                status_next    = ST_OK;
                                count_out_next = COUNT_W'(count_reg + CW'(1));
                            end
                        end
                        OP_POP_HEAD:
                        begin
                            if (q_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                head_next  = nxt(head_reg);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_TAIL:
                        begin
                            if (q_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = prv(tail_reg);
                                tail_next  = prv(tail_reg);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (q_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_addr  = head_reg;
                                ptr_next = head_reg;
                                idx_next = '0;
                                key_next = desc_in;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next      = 1'b1;
                status_next    = ST_OK;
                desc_out_next  = rd_desc;
                stamp_out_next = rd_stamp;
                count_out_next = COUNT_W'(count_reg);
            end
            S_SCAN:
            begin
                rd_addr = nxt(ptr_reg);
                if (match)
                begin
                    status_next    = ST_OK;
                    desc_out_next  = rd_desc;
                    stamp_out_next = rd_stamp;
                    count_next     = count_reg - CW'(1);
                    tail_next      = prv(tail_reg);
                    count_out_next = COUNT_W'(count_reg - CW'(1));
                    src_next       = nxt(ptr_reg);
                    done_next      = last_scan;
                end
                else if (last_scan)
                begin
                    done_next      = 1'b1;
                    status_next    = ST_NOTFOUND;
                    count_out_next = COUNT_W'(count_reg);
                end
                else
                begin
                    ptr_next = nxt(ptr_reg);
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SHIFT:
            begin
                // entry at src moves down into ptr
                wr_en     = 1'b1;
                wr_addr   = ptr_reg;
                wr_data   = rd_data;
                rd_addr   = nxt(src_reg);
                ptr_next  = src_reg;
                src_next  = nxt(src_reg);
                idx_next  = idx_reg + AW'(1);
                done_next = last_shift;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        src_reg       <= src_next;
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        status_reg    <= status_next;
        desc_out_reg  <= desc_out_next;
        stamp_out_reg <= stamp_out_next;
        count_out_reg <= count_out_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign desc_out  = desc_out_reg;
    assign stamp_out = stamp_out_reg;
    assign count_out = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_t'(op) == OP_APPEND && q_full)
        |=> (done && status == ST_FULL && $stable(count_reg)))
        else $error("append to full queue not refused");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (desc_out == '0 && stamp_out == '0))
        else $error("failed item returned entry data");

endmodule
